// File: rtl/gbph_pkg.sv
// Shared types and constants for the GIF block parser and frame hasher.
`default_nettype none
package gbph_pkg;

	// Block introducers and labels of the GIF block sequence.
	localparam logic [7:0] BLOCK_TRAILER = 8'h3B;
	localparam logic [7:0] BLOCK_EXT     = 8'h21;
	localparam logic [7:0] BLOCK_IMAGE   = 8'h2C;
	localparam logic [7:0] LABEL_GCE     = 8'hF9;

	// Bits of the image descriptor packed field.
	localparam int unsigned PACKED_LCT_BIT       = 7;
	localparam int unsigned PACKED_INTERLACE_BIT = 6;

	// Minimum size of a graphic control extension that carries a delay.
	localparam logic [7:0] GCE_MIN_SIZE = 8'd4;

	// Position and size bytes of an image descriptor.
	localparam logic [9:0] DESC_SKIP_LEN = 10'd8;

	// Byte indexes inside the graphic control extension.
	localparam logic [7:0] GCE_DELAY_LO  = 8'd1;
	localparam logic [7:0] GCE_DELAY_HI  = 8'd2;
	localparam logic [7:0] GCE_DELAY_FIX = 8'd3;

	localparam logic [15:0] DEFAULT_DELAY = 16'd10;

	// FNV-1a 32 constants.
	localparam logic [31:0] FNV_PRIME = 32'h0100_0193;
	localparam logic [31:0] FNV_BASIS = 32'h811C_9DC5;

	typedef enum logic [3:0] {
		PH_BLOCK       = 4'd0,
		PH_EXT_LABEL   = 4'd1,
		PH_GCE_SIZE    = 4'd2,
		PH_GCE_DATA    = 4'd3,
		PH_GCE_TERM    = 4'd4,
		PH_EXT_SUBSIZE = 4'd5,
		PH_EXT_SUBSKIP = 4'd6,
		PH_DESC_SKIP   = 4'd7,
		PH_DESC_PACKED = 4'd8,
		PH_LCT_SKIP    = 4'd9,
		PH_CODE_SIZE   = 4'd10,
		PH_DATA_SIZE   = 4'd11,
		PH_DATA_BYTE   = 4'd12
	} phase_t;

	typedef enum logic [2:0] {
		K_DATA       = 3'd0,
		K_FRAME      = 3'd1,
		K_END        = 3'd2,
		K_INTERLACED = 3'd3,
		K_TRUNC      = 3'd4
	} kind_t;

	// One result item as produced by the parser.
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data_byte;
		logic [15:0] frame_delay;
		logic [7:0]  code_size;
		logic [31:0] frame_hash;
	} result_t;

endpackage
`default_nettype wire

// File: rtl/gbph_if.sv
// Valid/ready channel interfaces for the stream input and the result output.
`default_nettype none
interface gbph_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] stream_byte;
	logic       stream_end;

	modport source (output valid, output stream_byte, output stream_end, input ready);
	modport sink (input valid, input stream_byte, input stream_end, output ready);
endinterface

interface gbph_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [7:0]  data_byte;
	logic [15:0] frame_delay;
	logic [7:0]  code_size;
	logic [31:0] frame_hash;

	modport source (output valid, output kind, output data_byte, output frame_delay,
		output code_size, output frame_hash, input ready);
	modport sink (input valid, input kind, input data_byte, input frame_delay,
		input code_size, input frame_hash, output ready);
endinterface
`default_nettype wire

// File: rtl/gbph_fnv.sv
// One FNV-1a 32 hash step: xor in a byte, multiply by the FNV prime.
`default_nettype none
module gbph_fnv (
	input  wire logic [31:0] hash_in,
	input  wire logic [7:0]  data,
	output logic [31:0]      hash_res
);

	logic [31:0] mixed;

	// The prime is 2^24 + 2^8 + 2^7 + 2^4 + 2^1 + 1, so the product is a sum of shifts.
	always_comb begin
		mixed    = hash_in ^ {24'd0, data};
		hash_res = (mixed << 24) + (mixed << 8) + (mixed << 7) + (mixed << 4)
			+ (mixed << 1) + mixed;
	end

endmodule
`default_nettype wire

// File: rtl/gbph_parser.sv
// Block sequence state machine with delay, code size and frame hash tracking.
`default_nettype none
module gbph_parser (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             step,
	input  wire logic [7:0]       stream_byte,
	input  wire logic             stream_end,
	output logic                  res_valid,
	output gbph_pkg::result_t     res
);

	gbph_pkg::phase_t phase_q, phase_n;
	logic [9:0]  skip_q, skip_n;
	logic [7:0]  ext_size_q, ext_size_n;
	logic [7:0]  ext_index_q, ext_index_n;
	logic [7:0]  ext_index_inc;
	logic [15:0] delay_q, delay_n;
	logic [7:0]  code_size_q, code_size_n;
	logic [31:0] hash_q, hash_n;
	logic [31:0] hash_seed;
	logic [31:0] hash_next;
	logic        in_image;

	// The code size byte starts a fresh hash; data bytes extend the running one.
	assign hash_seed = (phase_q == gbph_pkg::PH_CODE_SIZE) ? gbph_pkg::FNV_BASIS : hash_q;

	gbph_fnv u_fnv (
		.hash_in  (hash_seed),
		.data     (stream_byte),
		.hash_res (hash_next)
	);

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= gbph_pkg::PH_BLOCK;
			skip_q      <= '0;
			ext_size_q  <= '0;
			ext_index_q <= '0;
			delay_q     <= gbph_pkg::DEFAULT_DELAY;
			code_size_q <= '0;
			hash_q      <= gbph_pkg::FNV_BASIS;
		end else if (step) begin
			phase_q     <= phase_n;
			skip_q      <= skip_n;
			ext_size_q  <= ext_size_n;
			ext_index_q <= ext_index_n;
			delay_q     <= delay_n;
			code_size_q <= code_size_n;
			hash_q      <= hash_n;
		end
	end

	// Next state and result for the byte at hand.
	always_comb begin
		phase_n       = phase_q;
		skip_n        = skip_q;
		ext_size_n    = ext_size_q;
		ext_index_n   = ext_index_q;
		delay_n       = delay_q;
		code_size_n   = code_size_q;
		hash_n        = hash_q;
		ext_index_inc = ext_index_q + 8'd1;
		res_valid     = 1'b0;
		res           = '0;
		res.kind      = gbph_pkg::K_DATA;
		in_image      = (phase_q >= gbph_pkg::PH_DESC_SKIP) &&
			(phase_q <= gbph_pkg::PH_DATA_BYTE);

		if (stream_end) begin
			// End of file: truncated inside an image, a clean end elsewhere.
			phase_n   = gbph_pkg::PH_BLOCK;
			skip_n    = '0;
			delay_n   = gbph_pkg::DEFAULT_DELAY;
			hash_n    = gbph_pkg::FNV_BASIS;
			res_valid = 1'b1;
			res.kind  = in_image ? gbph_pkg::K_TRUNC : gbph_pkg::K_END;
		end else begin
			case (phase_q)
				gbph_pkg::PH_BLOCK: begin
					if (stream_byte == gbph_pkg::BLOCK_TRAILER) begin
						skip_n    = '0;
						delay_n   = gbph_pkg::DEFAULT_DELAY;
						hash_n    = gbph_pkg::FNV_BASIS;
						res_valid = 1'b1;
						res.kind  = gbph_pkg::K_END;
					end else if (stream_byte == gbph_pkg::BLOCK_EXT) begin
						phase_n = gbph_pkg::PH_EXT_LABEL;
					end else if (stream_byte == gbph_pkg::BLOCK_IMAGE) begin
						skip_n  = gbph_pkg::DESC_SKIP_LEN;
						phase_n = gbph_pkg::PH_DESC_SKIP;
					end
				end
				gbph_pkg::PH_EXT_LABEL: begin
					phase_n = (stream_byte == gbph_pkg::LABEL_GCE) ?
						gbph_pkg::PH_GCE_SIZE : gbph_pkg::PH_EXT_SUBSIZE;
				end
				gbph_pkg::PH_GCE_SIZE: begin
					ext_size_n  = stream_byte;
					ext_index_n = '0;
					phase_n     = (stream_byte >= gbph_pkg::GCE_MIN_SIZE) ?
						gbph_pkg::PH_GCE_DATA : gbph_pkg::PH_GCE_TERM;
				end
				gbph_pkg::PH_GCE_DATA: begin
					// Delay low byte, high byte, then a zero delay turns into the default.
					if (ext_index_q == gbph_pkg::GCE_DELAY_LO) begin
						delay_n = {delay_q[15:8], stream_byte};
					end else if (ext_index_q == gbph_pkg::GCE_DELAY_HI) begin
						delay_n = {stream_byte, delay_q[7:0]};
					end else if (ext_index_q == gbph_pkg::GCE_DELAY_FIX) begin
						if (delay_q == 16'd0) begin
							delay_n = gbph_pkg::DEFAULT_DELAY;
						end
					end
					ext_index_n = ext_index_inc;
					if (ext_index_inc >= ext_size_q) begin
						phase_n = gbph_pkg::PH_GCE_TERM;
					end
				end
				gbph_pkg::PH_GCE_TERM: begin
					phase_n = gbph_pkg::PH_BLOCK;
				end
				gbph_pkg::PH_EXT_SUBSIZE: begin
					if (stream_byte == 8'd0) begin
						phase_n = gbph_pkg::PH_BLOCK;
					end else begin
						skip_n  = {2'b00, stream_byte};
						phase_n = gbph_pkg::PH_EXT_SUBSKIP;
					end
				end
				gbph_pkg::PH_EXT_SUBSKIP: begin
					skip_n = skip_q - 10'd1;
					if (skip_q == 10'd1) begin
						phase_n = gbph_pkg::PH_EXT_SUBSIZE;
					end
				end
				gbph_pkg::PH_DESC_SKIP: begin
					skip_n = skip_q - 10'd1;
					if (skip_q == 10'd1) begin
						phase_n = gbph_pkg::PH_DESC_PACKED;
					end
				end
				gbph_pkg::PH_DESC_PACKED: begin
					if (stream_byte[gbph_pkg::PACKED_INTERLACE_BIT]) begin
						phase_n   = gbph_pkg::PH_BLOCK;
						skip_n    = '0;
						delay_n   = gbph_pkg::DEFAULT_DELAY;
						hash_n    = gbph_pkg::FNV_BASIS;
						res_valid = 1'b1;
						res.kind  = gbph_pkg::K_INTERLACED;
					end else if (stream_byte[gbph_pkg::PACKED_LCT_BIT]) begin
						// Local colour table holds 3 * 2^(n+1) bytes.
						skip_n  = 10'd3 << ({1'b0, stream_byte[2:0]} + 4'd1);
						phase_n = gbph_pkg::PH_LCT_SKIP;
					end else begin
						phase_n = gbph_pkg::PH_CODE_SIZE;
					end
				end
				gbph_pkg::PH_LCT_SKIP: begin
					skip_n = skip_q - 10'd1;
					if (skip_q == 10'd1) begin
						phase_n = gbph_pkg::PH_CODE_SIZE;
					end
				end
				gbph_pkg::PH_CODE_SIZE: begin
					code_size_n = stream_byte;
					hash_n      = hash_next;
					phase_n     = gbph_pkg::PH_DATA_SIZE;
				end
				gbph_pkg::PH_DATA_SIZE: begin
					if (stream_byte == 8'd0) begin
						// Zero sub-block closes the frame.
						phase_n         = gbph_pkg::PH_BLOCK;
						skip_n          = '0;
						delay_n         = gbph_pkg::DEFAULT_DELAY;
						hash_n          = gbph_pkg::FNV_BASIS;
						res_valid       = 1'b1;
						res.kind        = gbph_pkg::K_FRAME;
						res.frame_delay = delay_q;
						res.code_size   = code_size_q;
						res.frame_hash  = hash_q;
					end else begin
						skip_n  = {2'b00, stream_byte};
						phase_n = gbph_pkg::PH_DATA_BYTE;
					end
				end
				gbph_pkg::PH_DATA_BYTE: begin
					hash_n        = hash_next;
					skip_n        = skip_q - 10'd1;
					if (skip_q == 10'd1) begin
						phase_n = gbph_pkg::PH_DATA_SIZE;
					end
					res_valid     = 1'b1;
					res.kind      = gbph_pkg::K_DATA;
					res.data_byte = stream_byte;
				end
				default: begin
					phase_n = gbph_pkg::PH_BLOCK;
					skip_n  = '0;
					delay_n = gbph_pkg::DEFAULT_DELAY;
					hash_n  = gbph_pkg::FNV_BASIS;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// File: rtl/gif_block_parser_hasher_top.sv
// Top level of the GIF block parser and frame hasher.
// One stream item is accepted per cycle while no result item waits unaccepted.
// An accepted item is held in the input register, and its result item, if any, is
// written to the result register when the parser steps on that item.
// While a result item waits, both stages hold; a full input register stalls input.
// Asynchronous reset clears both stages and puts the parser back to expecting a block type.
`default_nettype none
module gif_block_parser_hasher_top (
	input  wire logic    clk,
	input  wire logic    arst_n,
	gbph_in_if.sink      stream,
	gbph_out_if.source   result
);

	logic              s1_valid_q;
	logic [7:0]        byte_s1;
	logic              end_s1;
	logic              out_valid_q;
	gbph_pkg::result_t out_q;
	logic              advance;
	logic              step;
	logic              res_valid;
	gbph_pkg::result_t res;

	// The stage moves whenever the output register is empty or being drained.
	assign advance      = !out_valid_q || result.ready;
	assign step         = s1_valid_q && advance;
	assign stream.ready = !s1_valid_q || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (stream.ready) begin
			s1_valid_q <= stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.valid && stream.ready) begin
			byte_s1 <= stream.stream_byte;
			end_s1  <= stream.stream_end;
		end
	end

	gbph_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.stream_byte (byte_s1),
		.stream_end  (end_s1),
		.res_valid   (res_valid),
		.res         (res)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_valid) begin
			out_q <= res;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.kind        = out_q.kind;
	assign result.data_byte   = out_q.data_byte;
	assign result.frame_delay = out_q.frame_delay;
	assign result.code_size   = out_q.code_size;
	assign result.frame_hash  = out_q.frame_hash;

endmodule
`default_nettype wire
